// ----- src/rlss_pkg.sv -----
// rlss_pkg: shared constants, request/response structs for the serial divider
// no dependencies
package rlss_pkg;

  localparam int unsigned DivW = 25;
  localparam logic [23:0] SPD_EPS = 24'd66;
  localparam logic [23:0] DT_MAX = 24'hFFFFFF;
  localparam logic signed [23:0] SPD_MIN = -24'sd8388608;
  localparam logic signed [23:0] SPD_MAX = 24'sd8388607;

  // register addresses (word index)
  localparam logic REG_ACCEL = 1'b0;
  localparam logic REG_TAU = 1'b1;

  typedef struct packed {
    logic start;
    logic [4:0] count;
    logic [DivW-1:0] rem;
    logic [DivW-1:0] lo;
    logic [DivW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [DivW-1:0] quo;
  } div_rsp_t;

endpackage

// ----- src/rlss_if.sv -----
// rlss_if: valid/ready channels for points and smoothed speeds
// depends on nothing
interface rlss_point_if;
  logic valid;
  logic ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [23:0] ref_speed;
  logic is_start;
  logic signed [23:0] start_speed;
  modport source(output valid, point_x, point_y, ref_speed, is_start, start_speed,
                 input ready);
  modport sink(input valid, point_x, point_y, ref_speed, is_start, start_speed,
               output ready);
endinterface

interface rlss_result_if;
  logic valid;
  logic ready;
  logic signed [23:0] smoothed_speed;
  logic [23:0] travel_time;
  modport source(output valid, smoothed_speed, travel_time, input ready);
  modport sink(input valid, smoothed_speed, travel_time, output ready);
endinterface

// ----- src/rlss_div.sv -----
// rlss_div: restoring divider, one quotient bit per cycle
// depends on rlss_pkg (div_req_t, div_rsp_t)
module rlss_div (
  input  logic clk,
  input  logic rst,
  input  rlss_pkg::div_req_t req,
  output rlss_pkg::div_rsp_t rsp
);

  logic [rlss_pkg::DivW-1:0] rem;
  logic [rlss_pkg::DivW-1:0] lo;
  logic [rlss_pkg::DivW-1:0] quo;
  logic [4:0] cnt;
  logic busy;
  logic done;
  logic [rlss_pkg::DivW:0] shifted;
  logic [rlss_pkg::DivW:0] diff;
  logic take;

  assign shifted = {rem, lo[rlss_pkg::DivW-1]};
  assign diff = shifted - {1'b0, req.divisor};
  assign take = !diff[rlss_pkg::DivW];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 5'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.rem;
      lo <= req.lo;
      cnt <= req.count;
      quo <= '0;
    end else if (busy) begin
      rem <= take ? diff[rlss_pkg::DivW-1:0] : shifted[rlss_pkg::DivW-1:0];
      lo <= {lo[rlss_pkg::DivW-2:0], 1'b0};
      quo <= {quo[rlss_pkg::DivW-2:0], take};
      cnt <= cnt - 5'd1;
    end
  end

  assign rsp.done = done;
  assign rsp.quo = quo;

endmodule

// ----- src/rate_limited_speed_smoother_core.sv -----
// rate_limited_speed_smoother_core: speed smoother top level with sequencer
// depends on rlss_pkg, rlss_if (interfaces) and rlss_div
//
// Points enter on the point channel (valid/ready), one smoothed speed and
// travel time leave on the result channel for every point. accel_limit and
// time_constant are written through the APB port (byte addresses 0 and 4).
// A start point or a point before the first start goes straight to the output step.
// A smoothed point runs through a bit-serial sequence: squaring of dx and
// dy, square root (two radicand bits a step), dt division (skipped when dt
// saturates), a prep step, multiplying, the blend division and an output
// step. Both divisions run on the shared one-bit-per-cycle divider; the
// products come from serial multipliers.
// One point is in work at a time; ready is high while the sequencer is idle.
// The result sits in an output register, so a new point is taken while a
// stalled result waits; the sequencer only holds at its last step when the
// output register is still full.
// Reset (rst, synchronous) clears the running speed, the previous position
// and the started flag, and loads both registers with 1.0.
module rate_limited_speed_smoother_core (
  input  logic clk,
  input  logic rst,
  rlss_point_if.sink point,
  rlss_result_if.source result,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_SQUARE = 8'b0000_0010,
    S_SQRT   = 8'b0000_0100,
    S_DIVDT  = 8'b0000_1000,
    S_PREP   = 8'b0001_0000,
    S_PROD   = 8'b0010_0000,
    S_DIVQ   = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_t;

  state_t state;
  logic [22:0] accel_limit;
  logic [23:0] time_constant;
  logic signed [31:0] prev_x;
  logic signed [31:0] prev_y;
  logic signed [23:0] running_speed;
  logic started;
  logic signed [23:0] ref_speed;

  logic [31:0] mx, my;
  logic [31:0] sqa, sqb;
  logic [63:0] acx, acy;
  logic [4:0] cnt;
  logic [63:0] sqn;
  logic ovf;
  logic [33:0] srem;
  logic [31:0] root;
  logic [23:0] dt;
  logic [24:0] den, mw, mdt, mdiff;
  logic dneg;
  logic [49:0] acc_p;
  logic [47:0] acc_l;
  logic div_go;
  logic signed [23:0] res_speed;
  logic [23:0] res_dt;
  logic out_valid;
  logic signed [23:0] out_speed;
  logic [23:0] out_dt;

  rlss_pkg::div_req_t div_req;
  rlss_pkg::div_rsp_t div_rsp;

  rlss_div u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  logic accept;
  logic signed [32:0] dx, dy;
  logic [31:0] ax, ay;
  logic [63:0] acx_next, acy_next;
  logic [64:0] sq_sum;
  logic [35:0] rem2;
  logic [35:0] trial;
  logic root_take;
  logic [31:0] root_next;
  logic [23:0] vmag, vdiv;
  logic [24:0] den_sum, den_next, w_next;
  logic signed [24:0] diff;
  logic [31:0] lim;
  logic [24:0] qmag;
  logic signed [25:0] delta, ns;
  logic signed [23:0] ns_sat;
  logic cfg_wr;

  assign accept = point.valid && point.ready;
  assign point.ready = (state == S_IDLE);

  assign dx = {point.point_x[31], point.point_x} - {prev_x[31], prev_x};
  assign dy = {point.point_y[31], point.point_y} - {prev_y[31], prev_y};
  assign ax = dx[32] ? 32'(-dx) : dx[31:0];
  assign ay = dy[32] ? 32'(-dy) : dy[31:0];

  // squaring keeps the magnitudes in sqa/sqb; the multiplier bits shift out of mx/my
  assign acx_next = (acx << 1) + (mx[31] ? {32'd0, sqa} : 64'd0);
  assign acy_next = (acy << 1) + (my[31] ? {32'd0, sqb} : 64'd0);
  assign sq_sum = {1'b0, acx_next} + {1'b0, acy_next};

  assign rem2 = {srem, sqn[63:62]};
  assign trial = {2'b00, root, 2'b01};
  assign root_take = (rem2 >= trial);
  assign root_next = {root[30:0], root_take};

  assign vmag = running_speed[23] ? 24'(-running_speed) : running_speed;
  assign vdiv = (vmag < rlss_pkg::SPD_EPS) ? rlss_pkg::SPD_EPS : vmag;

  assign den_sum = {1'b0, time_constant} + {1'b0, dt};
  assign den_next = (den_sum < {1'b0, rlss_pkg::SPD_EPS}) ? {1'b0, rlss_pkg::SPD_EPS}
                                                           : den_sum;
  assign w_next = den_next - {1'b0, time_constant};
  assign diff = {ref_speed[23], ref_speed} - {running_speed[23], running_speed};

  // clamp the blend step to the acceleration limit, then saturate
  assign lim = acc_l[47:16];
  assign qmag = ({7'd0, div_rsp.quo} > lim) ? lim[24:0] : div_rsp.quo;
  assign delta = dneg ? -$signed({1'b0, qmag}) : $signed({1'b0, qmag});
  assign ns = {{2{running_speed[23]}}, running_speed} + delta;
  assign ns_sat = (ns > 26'sd8388607) ? rlss_pkg::SPD_MAX :
                  (ns < -26'sd8388608) ? rlss_pkg::SPD_MIN : ns[23:0];

  always_comb begin
    div_req = '0;
    div_req.start = div_go;
    if (state == S_DIVDT) begin
      div_req.count = 5'd24;
      div_req.rem = {1'b0, root[31:8]};
      div_req.lo = {root[7:0], 17'd0};
      div_req.divisor = {1'b0, vdiv};
    end else begin
      div_req.count = 5'd25;
      div_req.rem = acc_p[49:25];
      div_req.lo = acc_p[24:0];
      div_req.divisor = den;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      prev_x <= '0;
      prev_y <= '0;
      running_speed <= '0;
      started <= 1'b0;
      div_go <= 1'b0;
    end else begin
      div_go <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            prev_x <= point.point_x;
            prev_y <= point.point_y;
            if (point.is_start) begin
              running_speed <= point.start_speed;
              started <= 1'b1;
              state <= S_OUT;
            end else if (!started) begin
              state <= S_OUT;
            end else begin
              state <= S_SQUARE;
            end
          end
        end
        S_SQUARE: begin
          if (cnt == 5'd0) state <= S_SQRT;
        end
        S_SQRT: begin
          if (cnt == 5'd0) begin
            // dt saturates when the sum overflowed or ds >= 256 * v
            if (ovf || root_next[31:8] >= vdiv) begin
              state <= S_PREP;
            end else begin
              state <= S_DIVDT;
              div_go <= 1'b1;
            end
          end
        end
        S_DIVDT: begin
          if (div_rsp.done) state <= S_PREP;
        end
        S_PREP: state <= S_PROD;
        S_PROD: begin
          if (cnt == 5'd0) begin
            state <= S_DIVQ;
            div_go <= 1'b1;
          end
        end
        S_DIVQ: begin
          if (div_rsp.done) begin
            running_speed <= ns_sat;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid || result.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          ref_speed <= point.ref_speed;
          mx <= ax;
          my <= ay;
          sqa <= ax;
          sqb <= ay;
          acx <= '0;
          acy <= '0;
          cnt <= 5'd31;
          res_dt <= '0;
          res_speed <= point.is_start ? point.start_speed : point.ref_speed;
        end
      end
      S_SQUARE: begin
        acx <= acx_next;
        acy <= acy_next;
        mx <= {mx[30:0], 1'b0};
        my <= {my[30:0], 1'b0};
        if (cnt == 5'd0) begin
          sqn <= sq_sum[63:0];
          ovf <= sq_sum[64];
          srem <= '0;
          root <= '0;
          cnt <= 5'd31;
        end else begin
          cnt <= cnt - 5'd1;
        end
      end
      S_SQRT: begin
        sqn <= {sqn[61:0], 2'b00};
        srem <= root_take ? 34'(rem2 - trial) : rem2[33:0];
        root <= root_next;
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0 || ovf) dt <= rlss_pkg::DT_MAX;
      end
      S_DIVDT: begin
        if (div_rsp.done) dt <= div_rsp.quo[23:0];
      end
      S_PREP: begin
        den <= den_next;
        mw <= w_next;
        mdt <= {1'b0, dt};
        dneg <= diff[24];
        mdiff <= diff[24] ? 25'(-diff) : diff;
        acc_p <= '0;
        acc_l <= '0;
        cnt <= 5'd24;
        res_dt <= dt;
      end
      S_PROD: begin
        acc_p <= (acc_p << 1) + (mw[24] ? {25'd0, mdiff} : 50'd0);
        acc_l <= (acc_l << 1) + (mdt[24] ? {25'd0, accel_limit} : 48'd0);
        mw <= {mw[23:0], 1'b0};
        mdt <= {mdt[23:0], 1'b0};
        cnt <= cnt - 5'd1;
      end
      S_DIVQ: begin
        if (div_rsp.done) res_speed <= ns_sat;
      end
      S_OUT: ;
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && (!out_valid || result.ready)) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!out_valid || result.ready)) begin
      out_speed <= res_speed;
      out_dt <= res_dt;
    end
  end

  assign result.valid = out_valid;
  assign result.smoothed_speed = out_speed;
  assign result.travel_time = out_dt;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      accel_limit <= 23'd65536;
      time_constant <= 24'd65536;
    end else if (cfg_wr) begin
      if (paddr[2] == rlss_pkg::REG_ACCEL) accel_limit <= pwdata[22:0];
      else time_constant <= pwdata[23:0];
    end
  end

  always_comb begin
    if (paddr[2] == rlss_pkg::REG_TAU) prdata = {8'd0, time_constant};
    else prdata = {9'd0, accel_limit};
  end

  a_ready_drops: assert property (@(posedge clk) disable iff (rst)
    accept |=> !point.ready)
    else $error("point taken while a point is in work");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_DIVDT || state == S_DIVQ))
    else $error("divider finished outside a division step");

  a_load_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(state == S_OUT))
    else $error("result loaded outside the output step");

endmodule
